// ----- hw/rtl/bsra_pkg.sv -----
// Shared constants for the banker's safe resource allocator.
// Holds command, status and configuration codes. It has no dependencies.
package bsra_pkg;

    localparam int PROCS_DEF     = 8;
    localparam int RES_TYPES_DEF = 4;
    localparam int NREG          = 4;
    localparam int UNIT_W        = 8;

    localparam logic [1:0] CMD_DECLARE = 2'd0;
    localparam logic [1:0] CMD_REQUEST = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NEED    = 3'd1;
    localparam logic [2:0] ST_FREE    = 3'd2;
    localparam logic [2:0] ST_UNSAFE  = 3'd3;
    localparam logic [2:0] ST_HOLDING = 3'd4;

    localparam logic [NREG-1:0][UNIT_W-1:0] POOL_RESET = {8'd0, 8'd2, 8'd3, 8'd3};

endpackage

// ----- hw/rtl/bankers_safe_resource_allocator_core.sv -----
// Banker's allocator: one command beat in, one status beat out.
// Flow: declare, release and refused requests go from the execute state to the finish state,
// which loads the result register; a checked request adds a safety scan between the two,
// one process row read from the table memory per cycle.
// One command is in work at a time; a new one is accepted only in the idle state.
// Reset (aresetn, synchronous, active low) clears the tables and loads the pool values.
module bankers_safe_resource_allocator_core #(
    parameter int PROCS     = bsra_pkg::PROCS_DEF,
    parameter int RES_TYPES = bsra_pkg::RES_TYPES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [2:0] s_pid,
    input  logic [7:0] s_amount_0,
    input  logic [7:0] s_amount_1,
    input  logic [7:0] s_amount_2,
    input  logic [7:0] s_amount_3,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [7:0] m_free_after_0,
    output logic [7:0] m_free_after_1,
    output logic [7:0] m_free_after_2,
    output logic [7:0] m_free_after_3
);

    localparam int AW   = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int CW   = $clog2(PROCS + 1);
    localparam int WW   = 8 + AW + 1;
    localparam int ROWW = 3 * RES_TYPES * 8;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    typedef logic [RES_TYPES-1:0][7:0] vec_t;

    state_t state_reg;
    logic [1:0]  cmd_reg;
    logic [2:0]  pid_reg;
    vec_t        amt_reg;
    logic [AW-1:0] pid_addr;
    logic        in_range;

    vec_t        free_reg;
    logic [bsra_pkg::NREG-1:0][7:0] pool_reg;
    logic [PROCS-1:0] hold_reg;

    vec_t        claim_keep_reg, tent_held_reg, tent_rem_reg;
    logic [AW-1:0] sp_reg, ev_idx_reg;
    logic        ev_vld_reg;
    logic [PROCS-1:0] done_reg;
    logic [CW-1:0] cnt_reg;
    logic        found_reg;
    logic [RES_TYPES-1:0][WW-1:0] work_reg;

    logic [2:0]  status_reg;
    logic        m_valid_reg;
    logic [3:0][7:0] out_free_reg;

    logic [3:0][7:0] s_amt_all;
    vec_t        s_amt;

    logic        wr_en;
    logic [ROWW-1:0] wr_data, rd_data;
    logic [AW-1:0] rd_addr;
    vec_t        rd_claim, rd_held, rd_rem;

    assign s_amt_all = {s_amount_3, s_amount_2, s_amount_1, s_amount_0};
    always_comb begin
        for (int r = 0; r < RES_TYPES; r++) begin
            s_amt[r] = s_amt_all[r];
        end
    end

    assign pid_addr = AW'(pid_reg);
    assign in_range = (5'(pid_reg) < 5'(PROCS));
    assign {rd_claim, rd_held, rd_rem} = rd_data;

    // Request checks and release sums on the row read at accept.
    logic holding_row, need_viol, free_viol, others_hold;
    vec_t rel_free;
    logic [PROCS-1:0] pid_oh;
    always_comb begin
        logic [8:0] sum;
        holding_row = 1'b0;
        need_viol   = 1'b0;
        free_viol   = 1'b0;
        for (int r = 0; r < RES_TYPES; r++) begin
            sum = {1'b0, free_reg[r]} + {1'b0, rd_held[r]};
            rel_free[r] = sum[8] ? 8'hFF : sum[7:0];
            if (rd_held[r] != 8'd0) holding_row = 1'b1;
            if (amt_reg[r] > rd_rem[r]) need_viol = 1'b1;
            if (amt_reg[r] > free_reg[r]) free_viol = 1'b1;
        end
        for (int p = 0; p < PROCS; p++) begin
            pid_oh[p] = (pid_addr == AW'(p));
        end
        others_hold = |(hold_reg & ~pid_oh);
    end

    logic oor_nonzero;
    always_comb begin
        oor_nonzero = 1'b0;
        for (int r = 0; r < RES_TYPES; r++) begin
            if (amt_reg[r] != 8'd0) oor_nonzero = 1'b1;
        end
    end

    // Safety scan: evaluate the row that returns from the memory this cycle.
    vec_t ev_held, ev_rem;
    logic fits, take, pass_end, scan_safe, scan_unsafe;
    logic [CW-1:0] cnt_new;
    always_comb begin
        ev_held = (ev_idx_reg == pid_addr) ? tent_held_reg : rd_held;
        ev_rem  = (ev_idx_reg == pid_addr) ? tent_rem_reg  : rd_rem;
        fits = 1'b1;
        for (int r = 0; r < RES_TYPES; r++) begin
            if (WW'(ev_rem[r]) > work_reg[r]) fits = 1'b0;
        end
        take        = ev_vld_reg && !done_reg[ev_idx_reg] && fits;
        cnt_new     = cnt_reg + CW'(take);
        pass_end    = ev_vld_reg && (ev_idx_reg == AW'(PROCS - 1));
        scan_safe   = ev_vld_reg && (cnt_new == CW'(PROCS));
        scan_unsafe = !scan_safe && pass_end && !(found_reg || take);
    end

    // Memory address and write-back selection.
    always_comb begin
        rd_addr = (state_reg == S_SCAN) ? sp_reg : AW'(s_pid);
        wr_en   = 1'b0;
        wr_data = {claim_keep_reg, tent_held_reg, tent_rem_reg};
        if (state_reg == S_EXEC && in_range) begin
            if (cmd_reg == bsra_pkg::CMD_DECLARE && !holding_row) begin
                wr_en   = 1'b1;
                wr_data = {amt_reg, vec_t'('0), amt_reg};
            end else if (cmd_reg == bsra_pkg::CMD_RELEASE) begin
                wr_en   = 1'b1;
                wr_data = {rd_claim, vec_t'('0), rd_claim};
            end
        end else if (state_reg == S_SCAN && scan_safe) begin
            wr_en = 1'b1;
        end
    end

    bsra_mem #(.PROCS(PROCS), .RES_TYPES(RES_TYPES)) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (pid_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == S_IDLE);

    // Command sequencer, free counts and scan registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pool_reg    <= bsra_pkg::POOL_RESET;
            for (int r = 0; r < RES_TYPES; r++) free_reg[r] <= bsra_pkg::POOL_RESET[r];
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
            ev_vld_reg  <= 1'b0;
            done_reg    <= '0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            sp_reg      <= '0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (cfg_we) begin
                pool_reg[cfg_index] <= cfg_data;
                for (int r = 0; r < RES_TYPES; r++) begin
                    if (cfg_index == 2'(r) && hold_reg == '0) free_reg[r] <= cfg_data;
                end
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg   <= s_cmd;
                        pid_reg   <= s_pid;
                        amt_reg   <= s_amt;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    status_reg <= bsra_pkg::ST_OK;
                    state_reg  <= S_FIN;
                    claim_keep_reg <= rd_claim;
                    for (int r = 0; r < RES_TYPES; r++) begin
                        tent_held_reg[r] <= rd_held[r] + amt_reg[r];
                        tent_rem_reg[r]  <= rd_rem[r] - amt_reg[r];
                        work_reg[r]      <= WW'(free_reg[r] - amt_reg[r]);
                    end
                    if (!in_range) begin
                        if (cmd_reg == bsra_pkg::CMD_REQUEST && oor_nonzero)
                            status_reg <= bsra_pkg::ST_NEED;
                    end else if (cmd_reg == bsra_pkg::CMD_DECLARE) begin
                        if (holding_row) status_reg <= bsra_pkg::ST_HOLDING;
                    end else if (cmd_reg == bsra_pkg::CMD_REQUEST) begin
                        if (need_viol) begin
                            status_reg <= bsra_pkg::ST_NEED;
                        end else if (free_viol) begin
                            status_reg <= bsra_pkg::ST_FREE;
                        end else begin
                            state_reg  <= S_SCAN;
                            sp_reg     <= '0;
                            ev_vld_reg <= 1'b0;
                            done_reg   <= '0;
                            cnt_reg    <= '0;
                            found_reg  <= 1'b0;
                        end
                    end else if (cmd_reg == bsra_pkg::CMD_RELEASE) begin
                        hold_reg[pid_addr] <= 1'b0;
                        for (int r = 0; r < RES_TYPES; r++) begin
                            free_reg[r] <= others_hold ? rel_free[r] : pool_reg[r];
                        end
                    end
                end
                S_SCAN: begin
                    sp_reg     <= (sp_reg == AW'(PROCS - 1)) ? '0 : sp_reg + AW'(1);
                    ev_vld_reg <= 1'b1;
                    ev_idx_reg <= sp_reg;
                    if (take) begin
                        done_reg[ev_idx_reg] <= 1'b1;
                        for (int r = 0; r < RES_TYPES; r++) begin
                            work_reg[r] <= work_reg[r] + WW'(ev_held[r]);
                        end
                    end
                    cnt_reg   <= cnt_new;
                    found_reg <= pass_end ? 1'b0 : (found_reg || take);
                    if (scan_safe) begin
                        status_reg         <= bsra_pkg::ST_OK;
                        hold_reg[pid_addr] <= |tent_held_reg;
                        for (int r = 0; r < RES_TYPES; r++) begin
                            free_reg[r] <= free_reg[r] - amt_reg[r];
                        end
                        state_reg <= S_FIN;
                    end else if (scan_unsafe) begin
                        status_reg <= bsra_pkg::ST_UNSAFE;
                        state_reg  <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN && (!m_valid_reg || m_ready)) begin
            m_status <= status_reg;
            for (int r = 0; r < 4; r++) begin
                out_free_reg[r] <= (r < RES_TYPES) ? free_reg[r % RES_TYPES] : 8'd0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_free_after_0 = out_free_reg[0];
    assign m_free_after_1 = out_free_reg[1];
    assign m_free_after_2 = out_free_reg[2];
    assign m_free_after_3 = out_free_reg[3];

`ifndef SYNTHESIS
    a_cnt_matches_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (32'(cnt_reg) == $countones(done_reg)))
        else $error("scan count does not match finished flags");
    a_fin_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && (!m_valid_reg || m_ready)) |=> (m_valid && s_ready))
        else $error("result not delivered to output register");
    a_idle_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && hold_reg == '0 && !$past(cfg_we)) |->
            (free_reg == vec_t'(pool_reg[RES_TYPES-1:0])))
        else $error("free counts differ from pool while nothing is held");
`endif

endmodule

// ----- hw/rtl/bsra_mem.sv -----
// Process table memory: one row per process holding claim, held and need.
// Depends on bsra_pkg. Rows never written read as zero through valid bits.
module bsra_mem #(
    parameter int PROCS     = bsra_pkg::PROCS_DEF,
    parameter int RES_TYPES = bsra_pkg::RES_TYPES_DEF,
    localparam int AW       = (PROCS > 1) ? $clog2(PROCS) : 1,
    localparam int ROWW     = 3 * RES_TYPES * bsra_pkg::UNIT_W
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  logic [ROWW-1:0] wr_data,
    input  logic [AW-1:0]   rd_addr,
    output logic [ROWW-1:0] rd_data
);

    logic [ROWW-1:0]  mem [PROCS];
    logic [PROCS-1:0] row_vld_reg;
    logic [ROWW-1:0]  rd_raw_reg;
    logic             rd_vld_reg;

    // Storage write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw_reg <= mem[rd_addr];
    end

    // Row valid bits stand in for clearing the table at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= row_vld_reg[rd_addr] || (wr_en && (wr_addr == rd_addr) && 1'b0);
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for bankers_safe_resource_allocator_core.
// Depends on bsra_pkg and the core. A queue-fed driver, a predicting
// allocator copy and a checking monitor run under several idle patterns.
module testbench;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [2:0]       pid;
        logic [3:0][7:0]  amt;
    } cmd_beat_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [3:0][7:0]  free;
    } status_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_cmd = '0;
    logic [2:0] s_pid = '0;
    logic [7:0] s_amount_0 = '0, s_amount_1 = '0, s_amount_2 = '0, s_amount_3 = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_status;
    logic [7:0] m_free_after_0, m_free_after_1, m_free_after_2, m_free_after_3;

    bankers_safe_resource_allocator_core dut (.*);

    always #1 aclk = ~aclk;

    // Allocator state as the checker expects it.
    logic [7:0] pool_regs [4];
    logic [7:0] free_now [4];
    logic [7:0] claim_tab [8][4];
    logic [7:0] held_tab [8][4];
    logic [7:0] need_tab [8][4];

    cmd_beat_t    pending_cmds[$];
    status_beat_t expected_status[$];
    int idle_pct = 0;
    int stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_on = 1'b0;
    int mismatches = 0;
    int checked = 0;
    int status_seen [5] = '{0, 0, 0, 0, 0};

    function automatic bit anything_held();
        for (int p = 0; p < 8; p++)
            for (int r = 0; r < 4; r++)
                if (held_tab[p][r] != 0) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void reload_free();
        for (int r = 0; r < 4; r++) free_now[r] = pool_regs[r];
    endfunction

    // Banker's safety scan: look for an order in which every process finishes.
    function automatic bit state_is_safe();
        int  work [4];
        bit  done [8];
        int  count;
        bit  found;
        bit  fits;
        count = 0;
        for (int r = 0; r < 4; r++) work[r] = free_now[r];
        for (int p = 0; p < 8; p++) done[p] = 1'b0;
        while (count < 8) begin
            found = 1'b0;
            for (int p = 0; p < 8; p++) begin
                if (!done[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < 4; r++)
                        if (need_tab[p][r] > work[r]) fits = 1'b0;
                    if (fits) begin
                        for (int r = 0; r < 4; r++) work[r] += held_tab[p][r];
                        done[p] = 1'b1;
                        found = 1'b1;
                        count++;
                    end
                end
            end
            if (!found) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one accepted command and queue the status beat it must produce.
    function automatic void allocate_and_expect(cmd_beat_t c);
        status_beat_t e;
        logic [2:0]   st;
        bit           holding;
        int           sum;
        st = bsra_pkg::ST_OK;
        if (c.cmd == bsra_pkg::CMD_DECLARE) begin
            holding = 1'b0;
            for (int r = 0; r < 4; r++)
                if (held_tab[c.pid][r] != 0) holding = 1'b1;
            if (holding) st = bsra_pkg::ST_HOLDING;
            else
                for (int r = 0; r < 4; r++) begin
                    claim_tab[c.pid][r] = c.amt[r];
                    need_tab[c.pid][r]  = c.amt[r];
                end
        end else if (c.cmd == bsra_pkg::CMD_REQUEST) begin
            for (int r = 0; r < 4; r++)
                if (c.amt[r] > need_tab[c.pid][r]) st = bsra_pkg::ST_NEED;
            if (st == bsra_pkg::ST_OK)
                for (int r = 0; r < 4; r++)
                    if (c.amt[r] > free_now[r]) st = bsra_pkg::ST_FREE;
            if (st == bsra_pkg::ST_OK) begin
                for (int r = 0; r < 4; r++) begin
                    free_now[r]          -= c.amt[r];
                    held_tab[c.pid][r]   += c.amt[r];
                    need_tab[c.pid][r]   -= c.amt[r];
                end
                if (!state_is_safe()) begin
                    for (int r = 0; r < 4; r++) begin
                        free_now[r]          += c.amt[r];
                        held_tab[c.pid][r]   -= c.amt[r];
                        need_tab[c.pid][r]   += c.amt[r];
                    end
                    st = bsra_pkg::ST_UNSAFE;
                end
            end
        end else if (c.cmd == bsra_pkg::CMD_RELEASE) begin
            for (int r = 0; r < 4; r++) begin
                sum = free_now[r] + held_tab[c.pid][r];
                free_now[r] = (sum > 255) ? 8'd255 : sum[7:0];
                need_tab[c.pid][r] = claim_tab[c.pid][r];
                held_tab[c.pid][r] = '0;
            end
            if (!anything_held()) reload_free();
        end
        e.status = st;
        for (int r = 0; r < 4; r++) e.free[r] = free_now[r];
        expected_status.push_back(e);
    endfunction

    // Driver: offers pending beats, holding each one until accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            cmd_beat_t c;
            if (s_valid)
                allocate_and_expect({s_cmd, s_pid,
                    {s_amount_3, s_amount_2, s_amount_1, s_amount_0}});
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                c = pending_cmds.pop_front();
                s_valid    <= 1'b1;
                s_cmd      <= c.cmd;
                s_pid      <= c.pid;
                s_amount_0 <= c.amt[0];
                s_amount_1 <= c.amt[1];
                s_amount_2 <= c.amt[2];
                s_amount_3 <= c.amt[3];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and field-by-field comparison.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_on && ($urandom_range(0, 99) >= stall_pct);
            if (m_valid && m_ready) begin
                status_beat_t e;
                status_beat_t a;
                a = {m_status, m_free_after_3, m_free_after_2, m_free_after_1,
                     m_free_after_0};
                if (expected_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected status beat %h", a);
                end else begin
                    e = expected_status.pop_front();
                    checked++;
                    if (e.status <= bsra_pkg::ST_HOLDING) status_seen[e.status]++;
                    if (a !== e) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: beat %0d status exp %0d got %0d,",
                                      " free exp %h got %h"},
                                     checked, e.status, a.status, e.free, a.free);
                    end
                end
            end
        end
    end

    // Long receiver hold-off, counted here once the stimulus asks for it.
    initial begin
        wait (hold_go);
        hold_on <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_on <= 1'b0;
    end

    function automatic cmd_beat_t mk(logic [1:0] cmd, int pid, int a0, int a1, int a2, int a3);
        cmd_beat_t c;
        c.cmd = cmd;
        c.pid = pid[2:0];
        c.amt = {a3[7:0], a2[7:0], a1[7:0], a0[7:0]};
        return c;
    endfunction

    // Mostly well-formed traffic with small amounts, plus some full-range noise.
    function automatic cmd_beat_t random_cmd();
        cmd_beat_t c;
        int sel;
        sel = $urandom_range(0, 99);
        c.pid = 3'($urandom_range(0, 7));
        if (sel < 25) begin
            c.cmd = 2'($urandom_range(0, 3));
            for (int r = 0; r < 4; r++) c.amt[r] = 8'($urandom_range(0, 255));
        end else begin
            if (sel < 42) c.cmd = bsra_pkg::CMD_DECLARE;
            else if (sel < 82) c.cmd = bsra_pkg::CMD_REQUEST;
            else if (sel < 97) c.cmd = bsra_pkg::CMD_RELEASE;
            else c.cmd = bsra_pkg::CMD_NONE;
            for (int r = 0; r < 4; r++)
                c.amt[r] = (c.cmd == bsra_pkg::CMD_DECLARE) ?
                    8'($urandom_range(0, pool_regs[r] + 2)) : 8'($urandom_range(0, 3));
        end
        return c;
    endfunction

    task automatic write_pool(int idx, int val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx[1:0];
        cfg_data  <= val[7:0];
        pool_regs[idx] = val[7:0];
        if (!anything_held()) reload_free();
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_valid || expected_status.size() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // Stimulus sequence: directed checks, then four random phases.
    initial begin
        int pools [4][4];
        pools = '{'{255, 255, 255, 255}, '{0, 0, 0, 0}, '{5, 4, 3, 7}, '{2, 9, 1, 255}};
        for (int r = 0; r < 4; r++) pool_regs[r] = bsra_pkg::POOL_RESET[r];
        reload_free();
        for (int p = 0; p < 8; p++)
            for (int r = 0; r < 4; r++) begin
                claim_tab[p][r] = '0;
                held_tab[p][r]  = '0;
                need_tab[p][r]  = '0;
            end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: refusals of each kind, unsafe rollback, pool reload, unused command.
        pending_cmds.push_back(mk(bsra_pkg::CMD_REQUEST, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_REQUEST, 0, 1, 0, 0, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_DECLARE, 0, 3, 3, 2, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_DECLARE, 1, 3, 3, 2, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_REQUEST, 0, 2, 2, 2, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_REQUEST, 1, 1, 1, 0, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_REQUEST, 1, 0, 0, 3, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_REQUEST, 1, 0, 0, 1, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_DECLARE, 0, 1, 1, 1, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_NONE, 5, 255, 255, 255, 255));
        pending_cmds.push_back(mk(bsra_pkg::CMD_RELEASE, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_DECLARE, 7, 255, 255, 255, 255));
        pending_cmds.push_back(mk(bsra_pkg::CMD_REQUEST, 7, 255, 255, 255, 255));
        pending_cmds.push_back(mk(bsra_pkg::CMD_DECLARE, 7, 0, 0, 0, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_DECLARE, 3, 9, 0, 0, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_REQUEST, 2, 0, 0, 0, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_DECLARE, 3, 0, 0, 0, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_REQUEST, 1, 3, 3, 2, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_RELEASE, 1, 0, 0, 0, 0));
        pending_cmds.push_back(mk(bsra_pkg::CMD_RELEASE, 4, 0, 0, 0, 0));
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            for (int r = 0; r < 4; r++) write_pool(r, pools[ph][r]);
            idle_pct  <= (ph == 1 || ph == 3) ? 85 : (ph == 2 ? 37 : 0);
            stall_pct <= (ph == 2 || ph == 3) ? 85 : (ph == 1 ? 37 : 0);
            repeat (1) @(posedge aclk);
            for (int i = 0; i < 130; i++) pending_cmds.push_back(random_cmd());
            for (int p = 0; p < 8; p++)
                pending_cmds.push_back(mk(bsra_pkg::CMD_RELEASE, p, 0, 0, 0, 0));
            if (ph == 0) begin
                // Long receiver hold-off while the sender keeps offering.
                hold_go <= 1'b1;
            end
            wait_drained();
        end

        $display("Checked %0d status beats over five pool settings and four idle patterns.",
                 checked);
        $display("Outcomes: ok %0d, over need %0d, over free %0d, unsafe %0d, holding %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("ERROR: timeout");
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bsra_pkg.sv
hw/rtl/bsra_mem.sv
hw/rtl/bankers_safe_resource_allocator_core.sv
tb/testbench.sv
